// ----- design/framed_record_scan_and_free_run_finder_top_macros.svh -----
// ----------------------------------------------------------------------------
// framed record scanner assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef FRAMED_RECORD_SCAN_AND_FREE_RUN_FINDER_TOP_MACROS_SVH
`define FRAMED_RECORD_SCAN_AND_FREE_RUN_FINDER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FRSF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FRSF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/frsf_pkg.sv -----
// ----------------------------------------------------------------------------
// frsf_pkg
// shared types, constants and the sync word table of the record scanner
// ----------------------------------------------------------------------------
`default_nettype none

package frsf_pkg;

    // image size bound and position counter width
    localparam int IMAGE_BYTES  = 4096;
    localparam int POS_W        = (IMAGE_BYTES > 4096) ? $clog2(IMAGE_BYTES) : 12;
    localparam int OFFSET_W     = 12;

    // free run bookkeeping
    localparam int RUN_W        = 9;
    localparam int RUN_SAT      = 261;
    localparam int HEADER_BYTES = 6;

    // result queue
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // event codes
    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_NOROOM = 2'd2
    } event_kind_t;

    // one input transaction
    typedef struct packed {
        logic [7:0] mem_byte;
        logic       last_byte;
    } frsf_item_t;

    // one result transaction
    typedef struct packed {
        event_kind_t         event_kind;
        logic [OFFSET_W-1:0] event_offset;
        logic [7:0]          record_type;
        logic [7:0]          record_length;
        logic                last_result;
    } frsf_result_t;

    // results caused by one input byte, in delivery order
    typedef struct packed {
        logic [1:0]   count;
        frsf_result_t first;
        frsf_result_t second;
    } frsf_batch_t;

    // sync word 5C 0F FE E1, indexed by bytes already matched
    function automatic logic [7:0] sync_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0: val = 8'h5C;
            2'd1: val = 8'h0F;
            2'd2: val = 8'hFE;
            2'd3: val = 8'hE1;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- design/frsf_in_stage.sv -----
// ----------------------------------------------------------------------------
// frsf_in_stage
// input register: holds one byte until the scan core consumes it
// ----------------------------------------------------------------------------
`default_nettype none

module frsf_in_stage
    import frsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire frsf_item_t in_item,
    input  wire logic       take,
    output logic            hold_valid,
    output frsf_item_t      hold_item
);

    logic       valid_reg;
    logic       valid_next;
    frsf_item_t item_reg;

    // free when empty or when the held byte leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

`default_nettype wire

// ----- design/frsf_scan_core.sv -----
// ----------------------------------------------------------------------------
// frsf_scan_core
// sync word hunt, record header capture, payload skip and free run tracking
// ----------------------------------------------------------------------------
`default_nettype none

module frsf_scan_core
    import frsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       fire,
    input  wire frsf_item_t item,
    output frsf_batch_t     batch
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_SKIP
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [1:0]         matched_reg;
    logic [1:0]         matched_next;
    logic [7:0]         skip_reg;
    logic [7:0]         skip_next;
    logic [RUN_W-1:0]   run_reg;
    logic [RUN_W-1:0]   run_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   start_reg;
    logic [POS_W-1:0]   start_next;
    logic [7:0]         type_reg;
    logic [7:0]         type_next;
    logic               room_reg;
    logic               room_next;
    logic [7:0]         req_len_reg;

    logic               is_last;
    logic               run_clear;
    logic [2:0]         held_count;
    logic [POS_W-1:0]   end_pos;
    logic               rec_hit;
    logic [RUN_W-1:0]   target;
    logic [RUN_W-1:0]   run_sum;
    logic               free_hit;
    logic               noroom_hit;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   free_off;
    frsf_result_t       rec_res;
    frsf_result_t       free_res;
    frsf_result_t       noroom_res;

    assign is_last = item.last_byte || (pos_reg >= POS_W'(IMAGE_BYTES - 1));

    // phase decode and sync word matching
    always_comb
    begin
        phase_next   = phase_reg;
        matched_next = matched_reg;
        skip_next    = skip_reg;
        start_next   = start_reg;
        type_next    = type_reg;
        run_clear    = 1'b0;
        held_count   = 3'd0;
        end_pos      = pos_reg;
        rec_hit      = 1'b0;
        unique case (phase_reg)
            PH_TYPE:
            begin
                type_next  = item.mem_byte;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                rec_hit    = 1'b1;
                skip_next  = item.mem_byte;
                phase_next = (item.mem_byte != 8'd0) ? PH_SKIP : PH_HUNT;
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 8'd1;
                if (skip_reg == 8'd1)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_HUNT:
            begin
                if (item.mem_byte == sync_byte(matched_reg))
                begin
                    if (matched_reg == 2'd0)
                    begin
                        start_next = pos_reg;
                    end
                    if (matched_reg == 2'd3)
                    begin
                        matched_next = 2'd0;
                        run_clear    = 1'b1;
                        phase_next   = PH_TYPE;
                    end
                    else
                    begin
                        matched_next = matched_reg + 2'd1;
                    end
                end
                else if (item.mem_byte == sync_byte(2'd0))
                begin
                    // broken match: held bytes go free, this byte opens a new match
                    held_count   = {1'b0, matched_reg};
                    start_next   = pos_reg;
                    matched_next = 2'd1;
                    end_pos      = pos_reg - POS_W'(1);
                end
                else
                begin
                    // broken match or plain byte: held bytes and this one go free
                    held_count   = {1'b0, matched_reg} + 3'd1;
                    matched_next = 2'd0;
                end
            end
        endcase
        // partial sync word at image end counts as free
        if (is_last && (phase_next == PH_HUNT))
        begin
            held_count = held_count + {1'b0, matched_next};
            end_pos    = pos_reg;
        end
    end

    // free run threshold, first crossing position and saturation
    assign target    = RUN_W'(req_len_reg) + RUN_W'(HEADER_BYTES);
    assign run_sum   = run_reg + RUN_W'(held_count);
    assign free_hit  = !room_reg && (held_count != 3'd0) && (run_sum >= target);
    assign start_pos = end_pos - POS_W'(held_count) + POS_W'(1);
    assign free_off  = (run_reg >= target) ? (start_pos - POS_W'(target) + POS_W'(1))
                                           : (start_pos - POS_W'(run_reg));
    assign run_next  = run_clear ? '0
                     : ((run_sum > RUN_W'(RUN_SAT)) ? RUN_W'(RUN_SAT) : run_sum);
    assign room_next  = room_reg || free_hit;
    assign noroom_hit = is_last && !room_next;

    // result formatting
    always_comb
    begin
        rec_res               = '0;
        rec_res.event_kind    = KIND_RECORD;
        rec_res.event_offset  = start_reg[OFFSET_W-1:0];
        rec_res.record_type   = type_reg;
        rec_res.record_length = item.mem_byte;

        free_res              = '0;
        free_res.event_kind   = KIND_FREE;
        free_res.event_offset = free_off[OFFSET_W-1:0];

        noroom_res             = '0;
        noroom_res.event_kind  = KIND_NOROOM;
        noroom_res.last_result = 1'b1;

        batch.count  = {1'b0, rec_hit} + {1'b0, free_hit} + {1'b0, noroom_hit};
        batch.second = noroom_res;
        if (rec_hit)
        begin
            batch.first = rec_res;
        end
        else if (free_hit)
        begin
            batch.first = free_res;
        end
        else
        begin
            batch.first = noroom_res;
        end
        batch.first.last_result = (batch.count == 2'd1);
    end

    // scan state, cleared at reset and after the final byte of an image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            matched_reg <= 2'd0;
            skip_reg    <= 8'd0;
            run_reg     <= '0;
            pos_reg     <= '0;
            start_reg   <= '0;
            type_reg    <= 8'd0;
            room_reg    <= 1'b0;
            req_len_reg <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                req_len_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                if (is_last)
                begin
                    phase_reg   <= PH_HUNT;
                    matched_reg <= 2'd0;
                    skip_reg    <= 8'd0;
                    run_reg     <= '0;
                    pos_reg     <= '0;
                    start_reg   <= '0;
                    type_reg    <= 8'd0;
                    room_reg    <= 1'b0;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    matched_reg <= matched_next;
                    skip_reg    <= skip_next;
                    run_reg     <= run_next;
                    pos_reg     <= pos_reg + POS_W'(1);
                    start_reg   <= start_next;
                    type_reg    <= type_next;
                    room_reg    <= room_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/frsf_out_queue.sv -----
// ----------------------------------------------------------------------------
// frsf_out_queue
// result register queue: takes up to two results a cycle, hands out one
// ----------------------------------------------------------------------------
`default_nettype none

module frsf_out_queue
    import frsf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire frsf_batch_t batch,
    output logic             room,
    output logic             out_valid,
    input  wire logic        out_ready,
    output frsf_result_t     out_result
);

    frsf_result_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic [1:0]          push_n;
    logic                pop;

    assign push_n     = push ? batch.count : 2'd0;
    assign pop        = out_valid && out_ready;
    assign count_next = count_reg + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(pop);

    // space for a full batch of two without looking at the receiver
    assign room = (count_reg <= (QPTR_W+1)'(QUEUE_DEPTH - 2));

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + QPTR_W'(push_n);
            rptr_reg  <= rptr_reg + QPTR_W'(pop);
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wptr_reg] <= batch.first;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wptr_reg + QPTR_W'(1)] <= batch.second;
        end
    end

    assign out_valid  = (count_reg != '0);
    assign out_result = entry_reg[rptr_reg];

endmodule

`default_nettype wire

// ----- design/framed_record_scan_and_free_run_finder_top.sv -----
// ----------------------------------------------------------------------------
// framed_record_scan_and_free_run_finder_top
// sync word framed record scanner with free run finder
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one image byte per transaction (tdata[7:0]); tlast marks
//   the final byte of an image. The byte at the image size bound also ends it.
//   m_axis carries events: tuser is the kind (record, free run, no room),
//   tdata the offset, record type and record length; tlast marks the last
//   event caused by one input byte. A byte causes zero, one or two events.
//   cfg_wr_en/cfg_wr_data load the requested payload length; write it only
//   while no byte is in flight and all events have been taken.
//   Event path: input register then result queue; an event is valid on m_axis
//   once its byte has left the input register and its events are queued.
//   Throughput: one byte per cycle while the queue has room for two events;
//   only the final byte of an image can cause two events; the queue takes both.
//   Reset clears the scan state and the length register to zero.
//   When the receiver stalls, events collect in a four-entry queue and input
//   is held off once fewer than two entries are free; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_record_scan_and_free_run_finder_top
    import frsf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    // image byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] mem_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // event stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [11:0] event_offset, [19:12] record_type,
                                             // [27:20] record_length, [31:28] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] event_kind
    output logic             m_axis_tlast    // last_result
);

    frsf_item_t   in_item;
    frsf_item_t   hold_item;
    logic         hold_valid;
    logic         take;
    logic         queue_room;
    frsf_batch_t  batch;
    frsf_result_t out_result;

    assign in_item.mem_byte  = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;

    // a held byte is processed whenever the queue can absorb its events
    assign take = hold_valid && queue_room;

    frsf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    frsf_scan_core u_scan_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (take),
        .item        (hold_item),
        .batch       (batch)
    );

    frsf_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .batch      (batch),
        .room       (queue_room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    // output packing
    assign m_axis_tdata = {4'd0, out_result.record_length, out_result.record_type,
                           out_result.event_offset};
    assign m_axis_tuser = out_result.event_kind;
    assign m_axis_tlast = out_result.last_result;

endmodule

`default_nettype wire

// ----- design/frsf_checker.sv -----
// ----------------------------------------------------------------------------
// frsf_checker
// port-level checks on the event stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "framed_record_scan_and_free_run_finder_top_macros.svh"

module frsf_checker
    import frsf_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // stalled event transaction keeps valid and payload
    `FRSF_ASSERT_NXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "event changed while stalled")

    // only records carry type and length
    `FRSF_ASSERT_IMP(a_nonrec_zero, clk, rst_n, m_axis_tvalid && (m_axis_tuser != KIND_RECORD), m_axis_tdata[31:12] == 20'd0, "non-record event with type or length")

    // no-room event has a zero offset and closes its byte's events
    `FRSF_ASSERT_IMP(a_noroom_form, clk, rst_n, m_axis_tvalid && (m_axis_tuser == KIND_NOROOM), (m_axis_tdata[11:0] == 12'd0) && m_axis_tlast, "malformed no-room event")

    // a free run is never followed by another event from the same byte
    `FRSF_ASSERT_IMP(a_free_last, clk, rst_n, m_axis_tvalid && (m_axis_tuser == KIND_FREE), m_axis_tlast, "free run event not last of its byte")

endmodule

bind framed_record_scan_and_free_run_finder_top frsf_checker u_frsf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- sim/tb_framed_record_scan_and_free_run_finder_top.sv -----
// ----------------------------------------------------------------------------
// tb_framed_record_scan_and_free_run_finder_top
// self-checking bench for the framed record scanner: image bytes go in on the
// slave stream, a scan model predicts the record, free run and no-room events
// of each byte, and every event transaction is checked field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb_framed_record_scan_and_free_run_finder_top;
    import frsf_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam logic [31:0] SYNC_PATTERN  = 32'h5C0FFEE1;
    localparam int          LONG_STALL    = 300;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          RANDOM_BYTES  = 1150;
    localparam int          TIMEOUT_TICKS = CLK_PERIOD * 600000;

    typedef enum logic [1:0] {
        SCAN_HUNT,
        SCAN_TYPE,
        SCAN_LENGTH,
        SCAN_PAYLOAD
    } scan_phase_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_SPARSE,
        RDY_PATTERN,
        RDY_COIN
    } ready_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] mem_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [11:0] event_offset, [19:12] record_type,
                                 // [27:20] record_length, [31:28] zero
    logic [1:0]  m_axis_tuser;   // [1:0] event_kind
    logic        m_axis_tlast;   // last_result

    framed_record_scan_and_free_run_finder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // scan model state and configuration shadow
    logic [7:0]   cfg_request_length;
    scan_phase_t  sc_phase;
    int           sc_matched;
    logic [7:0]   sc_skip;
    int           sc_run;
    int           sc_pos;
    int           sc_start;
    logic [7:0]   sc_type;
    bit           sc_found;

    // events of the current byte, and events still owed by the block
    frsf_result_t byte_events[$];
    frsf_result_t pending_events[$];

    // stimulus bookkeeping
    logic [7:0]   image_bytes[$];
    int           bytes_sent;
    int           burst_left;
    bit           sender_gaps;
    int           mismatches;

    // receiver stall control
    bit           hold_request;
    int           hold_left;
    int           mode_left;
    int           pattern_count;
    ready_mode_t  ready_mode;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_TICKS);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // scan model
    // ------------------------------------------------------------------------

    function automatic void add_event(input event_kind_t kind, input int offset,
                                      input logic [7:0] rec_type,
                                      input logic [7:0] rec_len);
        frsf_result_t ev;
        if (byte_events.size() >= 2)
            return;
        ev.event_kind    = kind;
        ev.event_offset  = offset[OFFSET_W-1:0];
        ev.record_type   = rec_type;
        ev.record_length = rec_len;
        ev.last_result   = 1'b0;
        byte_events.push_back(ev);
    endfunction

    // one byte joins the free run; first time it is long enough, report it
    function automatic void count_free_byte(input int at);
        int need;
        need = int'(cfg_request_length) + HEADER_BYTES;
        if (sc_run < RUN_SAT)
            sc_run++;
        if (!sc_found && sc_run >= need)
        begin
            sc_found = 1'b1;
            add_event(KIND_FREE, at - (need - 1), 8'd0, 8'd0);
        end
    endfunction

    function automatic void clear_scan_state();
        sc_phase   = SCAN_HUNT;
        sc_matched = 0;
        sc_skip    = 8'd0;
        sc_run     = 0;
        sc_pos     = 0;
        sc_start   = 0;
        sc_type    = 8'd0;
        sc_found   = 1'b0;
    endfunction

    function automatic void predict_scan_events(input logic [7:0] b, input logic tl);
        bit           at_end;
        int           here;
        frsf_result_t ev;
        byte_events.delete();
        at_end = tl || (sc_pos >= IMAGE_BYTES - 1);
        here   = sc_pos;

        case (sc_phase)
            SCAN_TYPE:
            begin
                sc_type  = b;
                sc_phase = SCAN_LENGTH;
            end
            SCAN_LENGTH:
            begin
                add_event(KIND_RECORD, sc_start, sc_type, b);
                sc_skip  = b;
                sc_phase = (b != 8'd0) ? SCAN_PAYLOAD : SCAN_HUNT;
            end
            SCAN_PAYLOAD:
            begin
                sc_skip = sc_skip - 8'd1;
                if (sc_skip == 8'd0)
                    sc_phase = SCAN_HUNT;
            end
            default:
            begin
                if (b == SYNC_PATTERN[8*(3-sc_matched) +: 8])
                begin
                    if (sc_matched == 0)
                        sc_start = here;
                    sc_matched++;
                    if (sc_matched >= 4)
                    begin
                        sc_matched = 0;
                        sc_run     = 0;
                        sc_phase   = SCAN_TYPE;
                    end
                end
                else
                begin
                    // broken sync word: held bytes join the run, then rescan
                    for (int k = 0; k < sc_matched; k++)
                        count_free_byte(sc_start + k);
                    sc_matched = 0;
                    if (b == SYNC_PATTERN[31:24])
                    begin
                        sc_start   = here;
                        sc_matched = 1;
                    end
                    else
                        count_free_byte(here);
                end
            end
        endcase

        // image end: flush a partial sync word, then decide on no room
        if (at_end)
        begin
            if (sc_phase == SCAN_HUNT)
                for (int k = 0; k < sc_matched; k++)
                    count_free_byte(sc_start + k);
            if (!sc_found)
                add_event(KIND_NOROOM, 0, 8'd0, 8'd0);
            clear_scan_state();
        end
        else
            sc_pos = here + 1;

        for (int i = 0; i < byte_events.size(); i++)
        begin
            ev = byte_events[i];
            ev.last_result = (i == byte_events.size() - 1);
            pending_events.push_back(ev);
        end
    endfunction

    // ------------------------------------------------------------------------
    // event checker
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : check_event
        frsf_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event transaction: kind %0d offset %0d",
                       m_axis_tuser, m_axis_tdata[11:0]);
                mismatches++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (m_axis_tuser != want.event_kind)
                begin
                    $error("event_kind: expected %0d, got %0d", want.event_kind, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[11:0] != want.event_offset)
                begin
                    $error("event_offset: expected %0d, got %0d",
                           want.event_offset, m_axis_tdata[11:0]);
                    mismatches++;
                end
                if (m_axis_tdata[19:12] != want.record_type)
                begin
                    $error("record_type: expected %0h, got %0h",
                           want.record_type, m_axis_tdata[19:12]);
                    mismatches++;
                end
                if (m_axis_tdata[27:20] != want.record_length)
                begin
                    $error("record_length: expected %0d, got %0d",
                           want.record_length, m_axis_tdata[27:20]);
                    mismatches++;
                end
                if (m_axis_tlast != want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d", want.last_result, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: changing stall patterns, plus an occasional long hold-off
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = LONG_STALL;
            hold_request = 1'b0;
        end
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        pattern_count++;

        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                RDY_ALWAYS:  m_axis_tready <= 1'b1;
                RDY_SPARSE:  m_axis_tready <= ($urandom_range(0, 4) == 0);
                RDY_PATTERN: m_axis_tready <= ((pattern_count % 7) > 2);
                default:     m_axis_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // sender and sequencing helpers
    // ------------------------------------------------------------------------

    // offer one byte, waiting out gaps between bursts, until it is taken
    task automatic send_byte(input logic [7:0] b, input logic tl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap        = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= tl;
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge clk);
        predict_scan_events(b, tl);
        bytes_sent++;
    endtask

    // up to eight bytes, most significant first
    task automatic send_byte_string(input logic [63:0] seq, input int n, input bit end_image);
        for (int i = 0; i < n; i++)
            send_byte(seq[8*(n-1-i) +: 8], end_image && (i == n - 1));
    endtask

    task automatic send_image_slice(input int from, input int upto, input bit end_image);
        for (int i = from; i < upto; i++)
            send_byte(image_bytes[i], end_image && (i == upto - 1));
    endtask

    // stop offering and wait until the block has nothing left in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_request_length(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_request_length = value;
    endtask

    function automatic logic [7:0] random_request_length();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3, 4, 5: return 8'($urandom_range(0, 12));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // any byte but the first sync byte
    function automatic logic [7:0] random_plain_byte();
        int v;
        v = $urandom_range(0, 254);
        if (v >= 8'h5C)
            v++;
        return 8'(v);
    endfunction

    // sync word, type, length and payload, mostly short
    function automatic void append_record();
        int len;
        case ($urandom_range(0, 19))
            0:       len = $urandom_range(0, 255);
            1, 2, 3, 4, 5: len = $urandom_range(7, 30);
            default: len = $urandom_range(0, 6);
        endcase
        for (int i = 0; i < 4; i++)
            image_bytes.push_back(SYNC_PATTERN[8*(3-i) +: 8]);
        image_bytes.push_back(8'($urandom_range(0, 255)));
        image_bytes.push_back(8'(len));
        for (int i = 0; i < len; i++)
            image_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_random_image();
        int segments;
        int run;
        int held;
        int cut_from;
        int cut_at;
        image_bytes.delete();
        segments = $urandom_range(1, 8);
        for (int s = 0; s < segments; s++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                    append_record();
                10, 11, 12, 13, 14:
                begin
                    run = $urandom_range(1, 20);
                    for (int i = 0; i < run; i++)
                        image_bytes.push_back(8'($urandom_range(0, 255)));
                end
                15, 16, 17:
                begin
                    // sync word that breaks partway, sometimes on a new 5C
                    held = $urandom_range(1, 3);
                    for (int i = 0; i < held; i++)
                        image_bytes.push_back(SYNC_PATTERN[8*(3-i) +: 8]);
                    image_bytes.push_back(($urandom_range(0, 2) == 0) ? SYNC_PATTERN[31:24]
                                                                      : random_plain_byte());
                end
                default:
                    image_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        // record cut short by the image end
        if ($urandom_range(0, 5) == 0)
        begin
            cut_from = image_bytes.size();
            append_record();
            cut_at = $urandom_range(cut_from + 1, image_bytes.size() - 1);
            while (image_bytes.size() > cut_at)
                void'(image_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // records of zero and nonzero length, a broken sync word, run found
    task automatic test_records_and_broken_sync();
        write_request_length(8'd0);
        send_byte_string(64'h5C0FFEE1AB00, 6, 1'b0);
        send_byte_string(64'h5C0FFEE1FF021234, 8, 1'b0);
        send_byte_string(64'h5C0F5C0FFE00, 6, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();
    endtask

    // partial sync word and cut records at the image end, record plus no room
    task automatic test_image_end_cases();
        write_request_length(8'd255);
        send_byte_string(64'h5C0F, 2, 1'b1);
        send_byte_string(64'h5C0FFEE101, 5, 1'b1);
        send_byte_string(64'h5C0FFEE1010A, 6, 1'b1);
        settle();
        write_request_length(8'd0);
        send_byte(8'h00, 1'b1);
        send_byte_string(64'h000000FF005C, 6, 1'b1);
        settle();
    endtask

    // shorter request written while a run is under way
    task automatic test_length_change_mid_scan();
        write_request_length(8'd20);
        for (int i = 0; i < 15; i++)
            send_byte(8'h11, 1'b0);
        settle();
        write_request_length(8'd3);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
        settle();
    endtask

    // long receiver hold-off while records keep coming
    task automatic test_output_backpressure();
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        for (int r = 0; r < 40; r++)
        begin
            send_byte_string(64'h5C0FFEE1, 4, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'h00, r == 39);
        end
        settle();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_images();
        int stop_at;
        int split;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 2) == 0)
                write_request_length(random_request_length());
            sender_gaps = ($urandom_range(0, 3) != 0);
            build_random_image();
            if (image_bytes.size() > 2 && $urandom_range(0, 7) == 0)
            begin
                // request length changes partway through the image
                split = $urandom_range(1, image_bytes.size() - 1);
                send_image_slice(0, split, 1'b0);
                settle();
                write_request_length(random_request_length());
                send_image_slice(split, image_bytes.size(), 1'b1);
            end
            else
                send_image_slice(0, image_bytes.size(), 1'b1);
            settle();
        end
        sender_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        hold_request  = 1'b0;
        hold_left     = 0;
        mode_left     = 0;
        pattern_count = 0;
        ready_mode    = RDY_ALWAYS;
        bytes_sent    = 0;
        burst_left    = 0;
        sender_gaps   = 1'b1;
        mismatches    = 0;
        cfg_request_length = 8'd0;
        clear_scan_state();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_records_and_broken_sync();
        test_image_end_cases();
        test_length_change_mid_scan();
        test_output_backpressure();
        test_random_images();

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
